/* rtl/lph_pkg.sv */
// Shared types and constants for the linear-probing hash set.
package lph_pkg;

   // Field widths of the request and response beats.
   localparam int KEY_W    = 64;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 10;

   // Key bits folded into the home-slot remainder per cycle.
   localparam int HASH_DIGIT_W = 8;
   localparam int HASH_STEPS   = KEY_W / HASH_DIGIT_W;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;

   // One command as it travels from the front end to the probe engine.
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
   } cmd_type;

endpackage

/* rtl/lph_front.sv */
// Front end: accepts request beats and computes the home slot of each key.
module lph_front #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [lph_pkg::OP_W-1:0]           req_op,
   input  logic [lph_pkg::KEY_W-1:0]          req_key,
   output logic                               cmd_valid,
   input  logic                               cmd_ready,
   output lph_pkg::cmd_type                   cmd,
   output logic [$clog2(TABLE_SIZE)-1:0]      cmd_home
);

   localparam int AW    = $clog2(TABLE_SIZE);
   localparam int RW    = $clog2(TABLE_SIZE - 1);
   localparam int RW1   = RW + 1;
   localparam int KW    = lph_pkg::KEY_W;
   localparam int DIG   = lph_pkg::HASH_DIGIT_W;
   localparam int NSTEP = lph_pkg::HASH_STEPS;
   localparam int CW    = $clog2(NSTEP);
   localparam logic [RW:0]   MODULUS   = RW1'(TABLE_SIZE - 1);
   localparam logic [CW-1:0] LAST_STEP = CW'(NSTEP - 1);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_HASH = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]       state_ff, state_in;
   lph_pkg::cmd_type cmd_ff, cmd_in;
   logic [KW-1:0]    shift_ff, shift_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [CW-1:0]    step_ff, step_in;
   logic [RW-1:0]    rem_step;

   // Fold one digit of the key, most significant first, into the remainder.
   // Each bit doubles the remainder and adds the bit; one subtract keeps it
   // below the modulus since the sum stays below twice the modulus.
   always_comb begin
      logic [RW-1:0] acc;
      logic [RW:0]   t;
      acc = rem_ff;
      for (int i = 0; i < DIG; i++) begin
         t = {acc, shift_ff[KW-1-i]};
         if (t >= MODULUS) begin
            t = t - MODULUS;
         end
         acc = t[RW-1:0];
      end
      rem_step = acc;
   end

   // Sequencer: take a beat, run the remainder over all digits, then hand off.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               cmd_in.op  = req_op;
               cmd_in.key = req_key;
               shift_in   = req_key;
               rem_in     = '0;
               step_in    = '0;
               state_in   = F_HASH;
            end
         end
         F_HASH: begin
            rem_in   = rem_step;
            shift_in = shift_ff << DIG;
            step_in  = step_ff + CW'(1);
            if (step_ff == LAST_STEP) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (cmd_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   // Key zero lives at slot 0; every other key starts one past its remainder.
   assign req_ready = (state_ff == F_IDLE);
   assign cmd_valid = (state_ff == F_PUSH);
   assign cmd       = cmd_ff;
   assign cmd_home  = (cmd_ff.key == '0) ? '0 : (AW'(rem_ff) + AW'(1));

endmodule

/* rtl/lph_queue.sv */
// Two-entry queue that decouples the front end from the probe engine.
module lph_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam logic [1:0] DEPTH = 2'd2;

   logic [WIDTH-1:0] entries_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != DEPTH);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* rtl/lph_back.sv */
// Probe engine: owns the slot memory, walks probe runs and drives responses.
module lph_back #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   output logic                               cmd_ready,
   input  lph_pkg::cmd_type                   cmd,
   input  logic [$clog2(TABLE_SIZE)-1:0]      cmd_home,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lph_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lph_pkg::SLOT_W-1:0]         rsp_slot
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int KW = lph_pkg::KEY_W;
   localparam int SW = lph_pkg::SLOT_W;
   localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

   localparam logic [1:0] B_CLEAR = 2'd0;
   localparam logic [1:0] B_IDLE  = 2'd1;
   localparam logic [1:0] B_PROBE = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [lph_pkg::OP_W-1:0]       op_ff, op_in;
   logic [KW-1:0]                  key_ff, key_in;
   logic [AW-1:0]                  addr_ff, addr_in;
   logic [AW-1:0]                  count_ff, count_in;
   logic [AW-1:0]                  clr_ff, clr_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lph_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SW-1:0]                  rsp_slot_ff, rsp_slot_in;

   logic [KW-1:0] slots_mem [TABLE_SIZE];
   logic [KW-1:0] rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [KW-1:0] mem_wd;

   logic          slot_empty;
   logic          slot_hit;
   logic          last_step;
   logic          op_known;
   logic          finish;
   logic          out_free;
   logic [AW-1:0] addr_next;

   // Classify the slot read for the current probe position.
   assign slot_empty = (rd_data_ff == '0);
   assign slot_hit   = (rd_data_ff == key_ff) || (key_ff == '0);
   assign last_step  = (count_ff == LAST);
   assign op_known   = (op_ff == lph_pkg::OP_ADD) || (op_ff == lph_pkg::OP_FIND) ||
                       (op_ff == lph_pkg::OP_REMOVE);
   assign finish     = !op_known || slot_empty || slot_hit || last_step;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign addr_next  = (addr_ff == LAST) ? '0 : (addr_ff + AW'(1));

   // Clearing pass, command pickup, one probe step per cycle; last may stall.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      mem_we        = 1'b0;
      mem_wa        = addr_ff;
      mem_wd        = '0;
      cmd_ready     = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               op_in    = cmd.op;
               key_in   = cmd.key;
               addr_in  = cmd_home;
               count_in = '0;
               state_in = B_PROBE;
            end
         end
         B_PROBE: begin
            if (!finish) begin
               addr_in  = addr_next;
               count_in = count_ff + AW'(1);
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = lph_pkg::ST_NOTFOUND;
               rsp_slot_in   = '0;
               state_in      = B_IDLE;
               if (op_known) begin
                  if (slot_empty) begin
                     // End of run: add stores the key here, key zero as one.
                     if (op_ff == lph_pkg::OP_ADD) begin
                        mem_we        = 1'b1;
                        mem_wd        = (key_ff == '0) ? KW'(1) : key_ff;
                        rsp_status_in = lph_pkg::ST_INSERTED;
                        rsp_slot_in   = SW'(addr_ff);
                     end
                  end else if (slot_hit) begin
                     rsp_slot_in = SW'(addr_ff);
                     if (op_ff == lph_pkg::OP_REMOVE) begin
                        mem_we        = 1'b1;
                        rsp_status_in = lph_pkg::ST_REMOVED;
                     end else begin
                        rsp_status_in = lph_pkg::ST_PRESENT;
                     end
                  end else if (op_ff == lph_pkg::OP_ADD) begin
                     // Wrapped all the way around with no room.
                     rsp_status_in = lph_pkg::ST_FULL;
                  end
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      addr_ff       <= addr_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // Slot memory: one write port, one registered read of the next probe slot.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= slots_mem[addr_in];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule

/* rtl/linear_probe_hash_set_top.sv */
// Top level of the linear-probing hash set of 64-bit keys.
// Usage:
//   Request channel (req_valid/req_ready) carries one beat per operation:
//   req_op selects add, find or remove and req_key is the key. The response
//   channel (rsp_valid/rsp_ready) returns one beat per request, in order,
//   with rsp_status and rsp_slot.
//   The front end folds the key into its home slot one byte per cycle: a
//   request there is accepted, hashed byte by byte and then handed off. A
//   two-entry queue feeds the probe engine, which picks up a command and
//   then examines the slots of its probe run in turn, since the slot memory
//   has one registered read port. The front end can take a new request once
//   it has handed off the last one, while the engine still works on earlier
//   ones. A full-table add or miss examines every slot.
//   After reset the probe engine clears the slot memory, one slot a cycle;
//   requests queue up meanwhile and then stall.
//   When rsp_ready is low the finished beat waits in the output register,
//   the engine holds its last probe step and the queue and front end keep
//   filling until they too stall req_ready.
module linear_probe_hash_set_top #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lph_pkg::OP_W-1:0]      req_op,
   input  logic [lph_pkg::KEY_W-1:0]     req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lph_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lph_pkg::SLOT_W-1:0]    rsp_slot
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int CMD_W = $bits(lph_pkg::cmd_type);
   localparam int QW = CMD_W + AW;

   logic             f_valid;
   logic             f_ready;
   lph_pkg::cmd_type f_cmd;
   logic [AW-1:0]    f_home;
   logic             b_valid;
   logic             b_ready;
   logic [QW-1:0]    b_data;
   lph_pkg::cmd_type b_cmd;
   logic [AW-1:0]    b_home;

   // Hashing front end.
   lph_front #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .req_key   (req_key),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd       (f_cmd),
      .cmd_home  (f_home)
   );

   // Command queue between the two halves.
   lph_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   ({f_cmd, f_home}),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   assign b_cmd  = b_data[QW-1:AW];
   assign b_home = b_data[AW-1:0];

   // Probe engine with the slot memory and response register.
   lph_back #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (b_valid),
      .cmd_ready  (b_ready),
      .cmd        (b_cmd),
      .cmd_home   (b_home),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot)
   );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the linear-probing hash set: a shadow table predicts every response.
module tb_top;

   localparam int TABLE_SIZE  = 1024;
   localparam int POOL_N      = 40;
   localparam int RANDOM_OPS  = 180;
   localparam int CYCLE_LIMIT = 5000000;

   // Operation code that the block does not implement.
   localparam logic [lph_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [lph_pkg::KEY_W-1:0] KEY_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [lph_pkg::STATUS_W-1:0] status;
      logic [lph_pkg::SLOT_W-1:0]   slot;
   } lookup_result_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [lph_pkg::OP_W-1:0]     req_op = '0;
   logic [lph_pkg::KEY_W-1:0]    req_key = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [lph_pkg::STATUS_W-1:0] rsp_status;
   logic [lph_pkg::SLOT_W-1:0]   rsp_slot;

   // Shadow copy of the slot store, and the traffic queues.
   logic [lph_pkg::KEY_W-1:0] shadow_slots [TABLE_SIZE];
   logic [lph_pkg::KEY_W-1:0] key_pool [POOL_N];
   lph_pkg::cmd_type          pending_cmds [$];
   lookup_result_type         expected_results [$];

   int send_idle_pct = 34;
   int recv_idle_pct = 49;
   int error_count   = 0;
   int cycle_count   = 0;

   linear_probe_hash_set_top #(.TABLE_SIZE(TABLE_SIZE)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Probe the shadow table for one operation, apply its effect and return the response.
   function automatic lookup_result_type probe_and_update(logic [lph_pkg::OP_W-1:0] op,
                                                          logic [lph_pkg::KEY_W-1:0] key);
      lookup_result_type res;
      int  home;
      int  idx;
      int  first_empty;
      int  n;
      bit  hit;
      bit  stop;
      res.status  = lph_pkg::ST_NOTFOUND;
      res.slot    = '0;
      if (op == lph_pkg::OP_ADD || op == lph_pkg::OP_FIND || op == lph_pkg::OP_REMOVE) begin
         home        = (key == '0) ? 0 : 1 + int'(key % (TABLE_SIZE - 1));
         idx         = home;
         hit         = 1'b0;
         first_empty = -1;
         if (shadow_slots[home] == '0) begin
            first_empty = home;
         end else if (shadow_slots[home] == key || key == '0) begin
            hit = 1'b1;
         end else begin
            // Walk forward with wrap-around until an empty slot or the key.
            stop = 1'b0;
            for (n = 1; n < TABLE_SIZE && !stop; n++) begin
               idx = (idx + 1 == TABLE_SIZE) ? 0 : idx + 1;
               if (shadow_slots[idx] == '0) begin
                  first_empty = idx;
                  stop = 1'b1;
               end else if (shadow_slots[idx] == key) begin
                  hit  = 1'b1;
                  stop = 1'b1;
               end
            end
         end
         case (op)
            lph_pkg::OP_ADD: begin
               if (hit) begin
                  res.status = lph_pkg::ST_PRESENT;
                  res.slot   = idx[lph_pkg::SLOT_W-1:0];
               end else if (first_empty >= 0) begin
                  // Key zero is kept as the marker value one.
                  shadow_slots[first_empty] = (key == '0) ? 64'd1 : key;
                  res.status = lph_pkg::ST_INSERTED;
                  res.slot   = first_empty[lph_pkg::SLOT_W-1:0];
               end else begin
                  res.status = lph_pkg::ST_FULL;
               end
            end
            lph_pkg::OP_FIND: begin
               if (hit) begin
                  res.status = lph_pkg::ST_PRESENT;
                  res.slot   = idx[lph_pkg::SLOT_W-1:0];
               end
            end
            default: begin
               if (hit) begin
                  shadow_slots[idx] = '0;
                  res.status = lph_pkg::ST_REMOVED;
                  res.slot   = idx[lph_pkg::SLOT_W-1:0];
               end
            end
         endcase
      end
      return res;
   endfunction

   // Mostly keys from clustered pools, some fresh random keys, some zero or one.
   function automatic logic [lph_pkg::KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
         return key_pool[$urandom_range(0, POOL_N - 1)];
      end else if (sel < 95) begin
         return {$urandom, $urandom};
      end else begin
         return ($urandom_range(0, 1) == 0) ? 64'd0 : 64'd1;
      end
   endfunction

   function automatic logic [lph_pkg::OP_W-1:0] pick_op();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         return lph_pkg::OP_ADD;
      end else if (sel < 70) begin
         return lph_pkg::OP_FIND;
      end else if (sel < 95) begin
         return lph_pkg::OP_REMOVE;
      end else begin
         return OP_UNUSED;
      end
   endfunction

   task automatic queue_cmd(logic [lph_pkg::OP_W-1:0] op, logic [lph_pkg::KEY_W-1:0] key);
      lph_pkg::cmd_type cmd;
      cmd.op  = op;
      cmd.key = key;
      pending_cmds.push_back(cmd);
   endtask

   // Sampled on the falling edge so the driver's updates have settled.
   task automatic wait_all_sent();
      while (pending_cmds.size() != 0 || req_valid) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: a beat is predicted when accepted, then the next one is offered.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_results.push_back(probe_and_update(req_op, req_key));
         end
         if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_op    <= pending_cmds[0].op;
            req_key   <= pending_cmds[0].key;
            void'(pending_cmds.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor: every accepted beat is checked against the oldest expectation.
   always @(posedge clock) begin : rsp_monitor
      lookup_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: response beat with none expected, status %0d slot %0d",
                        $time, rsp_status, rsp_slot);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status) begin
                  error_count++;
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_slot !== want.slot) begin
                  error_count++;
                  $display("%0t: slot mismatch, expected %0d, got %0d",
                           $time, want.slot, rsp_slot);
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("** linear_probe_hash_set_top: FAILED **");
      $finish;
   end

   initial begin : stimulus
      logic [lph_pkg::KEY_W-1:0] fill_keys [$];
      logic [lph_pkg::KEY_W-1:0] r;
      int                        cluster_base [4];
      int                        i;
      int                        c;
      int                        off;

      for (i = 0; i < TABLE_SIZE; i++) shadow_slots[i] = '0;

      // Build key clusters that share or neighbor home slots; one wraps past the end.
      cluster_base[0] = 1019;
      for (i = 1; i < 4; i++) cluster_base[i] = $urandom_range(0, 1022);
      for (i = 0; i < POOL_N; i++) begin
         r   = {$urandom, $urandom};
         off = (cluster_base[i % 4] + $urandom_range(0, 3)) % (TABLE_SIZE - 1);
         key_pool[i] = r - (r % (TABLE_SIZE - 1)) + 64'(off);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: key zero, extreme keys, collisions, holes left by remove, unused op.
      queue_cmd(lph_pkg::OP_ADD, 64'd0);
      queue_cmd(lph_pkg::OP_ADD, 64'd0);
      queue_cmd(lph_pkg::OP_FIND, 64'd0);
      queue_cmd(lph_pkg::OP_ADD, KEY_ALL_ONES);
      queue_cmd(lph_pkg::OP_ADD, KEY_ALL_ONES - 64'd1023);
      queue_cmd(lph_pkg::OP_FIND, KEY_ALL_ONES - 64'd1023);
      queue_cmd(lph_pkg::OP_REMOVE, KEY_ALL_ONES);
      queue_cmd(lph_pkg::OP_FIND, KEY_ALL_ONES - 64'd1023);
      queue_cmd(lph_pkg::OP_ADD, KEY_ALL_ONES - 64'd1023);
      queue_cmd(lph_pkg::OP_REMOVE, 64'd0);
      queue_cmd(lph_pkg::OP_FIND, 64'd0);
      queue_cmd(lph_pkg::OP_REMOVE, 64'd0);
      queue_cmd(OP_UNUSED, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_cmd(OP_UNUSED, 64'h5555_5555_5555_5555);
      queue_cmd(lph_pkg::OP_FIND, 64'h8000_0000_0000_0000);
      queue_cmd(lph_pkg::OP_ADD, 64'd1);
      queue_cmd(lph_pkg::OP_ADD, 64'd1023);
      queue_cmd(lph_pkg::OP_ADD, 64'd2046);
      queue_cmd(lph_pkg::OP_FIND, 64'd2046);
      queue_cmd(lph_pkg::OP_REMOVE, 64'd1);
      queue_cmd(lph_pkg::OP_FIND, 64'd2046);

      // Hold off new requests until every response is back.
      wait_drained();

      // Random traffic in three idling regimes.
      for (c = 0; c < 3; c++) begin
         wait_all_sent();
         if (c == 1) begin
            send_idle_pct = 49;
            recv_idle_pct = 34;
         end else if (c == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (i = 0; i < RANDOM_OPS / 3; i++) queue_cmd(pick_op(), pick_key());
      end

      // Hold off again, then take key zero and key one out so slot 0 gets only the marker.
      wait_drained();
      queue_cmd(lph_pkg::OP_REMOVE, 64'd0);
      queue_cmd(lph_pkg::OP_REMOVE, 64'd1);

      // Fill every slot; key 1024 takes key one's home.
      fill_keys.push_back(64'd0);
      fill_keys.push_back(64'd1023);
      fill_keys.push_back(64'd1024);
      for (i = 2; i < TABLE_SIZE - 1; i++) fill_keys.push_back(64'(i));
      for (i = 0; i < fill_keys.size(); i++) queue_cmd(lph_pkg::OP_ADD, fill_keys[i]);

      // Full table: add and miss scan the whole table; key one meets the zero marker.
      queue_cmd(lph_pkg::OP_ADD, 64'd5000);
      queue_cmd(lph_pkg::OP_FIND, 64'd5000);
      queue_cmd(lph_pkg::OP_FIND, 64'd1);
      queue_cmd(lph_pkg::OP_ADD, 64'd1);
      queue_cmd(lph_pkg::OP_REMOVE, 64'd1);
      // A wrapped insert lands in slot 0, which key zero then claims as its own.
      queue_cmd(lph_pkg::OP_ADD, 64'd2000);
      queue_cmd(lph_pkg::OP_ADD, 64'd0);
      queue_cmd(lph_pkg::OP_FIND, 64'd0);
      queue_cmd(lph_pkg::OP_REMOVE, 64'd0);

      wait_drained();
      repeat (TABLE_SIZE + 50) @(negedge clock);
      if (error_count == 0) begin
         $display("** linear_probe_hash_set_top: PASSED **");
      end else begin
         $display("** linear_probe_hash_set_top: FAILED **");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/lph_pkg.sv
rtl/lph_front.sv
rtl/lph_queue.sv
rtl/lph_back.sv
rtl/linear_probe_hash_set_top.sv
sim/tb_top.sv
